[sv/cvmap_pkg.sv]
// package for the cv to voice parameter mapper: constants, register codes, types, gain table
`default_nettype none

package cvmap_pkg;

	// stream and configuration widths
	localparam int IN_W   = 128;
	localparam int OUT_W  = 112;
	localparam int CIDX_W = 3;
	localparam int CDAT_W = 16;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] REG_PITCH_KNOB   = 3'd0;
	localparam logic [CIDX_W-1:0] REG_PITCH_WIDE   = 3'd1;
	localparam logic [CIDX_W-1:0] REG_FM_PATCHED   = 3'd2;
	localparam logic [CIDX_W-1:0] REG_DENSITY_KNOB = 3'd3;
	localparam logic [CIDX_W-1:0] REG_CADENCE_KNOB = 3'd4;
	localparam logic [CIDX_W-1:0] REG_TORQUE_KNOB  = 3'd5;
	localparam logic [CIDX_W-1:0] REG_SHAPE_KNOB   = 3'd6;

	// pitch knob span in semitones and low end plus 240 semitone bias, in 1/65536 semitone
	localparam logic [6:0]  SPAN_NARROW = 7'd26;
	localparam logic [6:0]  SPAN_WIDE   = 7'd96;
	localparam logic [25:0] OFF_NARROW  = 26'd17235968;
	localparam logic [25:0] OFF_WIDE    = 26'd14942208;

	// fm factor at unity, 5 * 2^22
	localparam logic signed [31:0] FM_UNITY = 32'sd20971520;
	localparam logic signed [15:0] FM_INDEX_ONE = 16'sd2048;

	// pulse frequency limits in 1/256 Hz and the matching limits before the divide by five
	localparam logic [22:0] FREQ_MIN = 23'd256;
	localparam logic [22:0] FREQ_MAX = 23'd5120000;
	localparam logic [46:0] X_MIN    = 47'd1280;
	localparam logic [46:0] X_OVER   = 47'd25600005;

	// reciprocals for exact division by constants
	localparam logic [19:0] RECIP5_22   = 20'd838861;
	localparam logic [24:0] RECIP5_27   = 25'd26843546;
	localparam logic [31:0] RECIP10K_45 = 32'd3518437209;
	localparam logic [21:0] LIN_OFFSET  = 22'd2621440;
	localparam logic [15:0] SHAPE_GAIN  = 16'd49999;

	// exponential fraction polynomial
	localparam logic [19:0] EXP_C1 = 20'd969090;
	localparam logic [14:0] EXP_C2 = 15'd27988;

	typedef struct packed {
		logic signed [15:0] density;
		logic [15:0]        ratio;
		logic [15:0]        depth;
		logic [18:0]        wave;
		logic [7:0]         lock;
		logic [7:0]         couple;
	} lin_t;

	// 7040 * 2^(r/12) in Q16, one entry per semitone in the octave
	function automatic logic [29:0] exp_gain(input logic [3:0] r);
		logic [29:0] g;
		case (r)
			4'd0:    g = 30'd461373440;
			4'd1:    g = 30'd488808320;
			4'd2:    g = 30'd517876480;
			4'd3:    g = 30'd548669440;
			4'd4:    g = 30'd581292800;
			4'd5:    g = 30'd615859200;
			4'd6:    g = 30'd652481280;
			4'd7:    g = 30'd691278720;
			4'd8:    g = 30'd732385280;
			4'd9:    g = 30'd775934720;
			4'd10:   g = 30'd822074880;
			4'd11:   g = 30'd870953600;
			default: g = 30'd0;
		endcase
		return g;
	endfunction

endpackage

`default_nettype wire

[sv/cv_to_voice_parameter_mapper.sv]
// top level of the cv to voice parameter mapper: eight stage pipeline
`default_nettype none

// Maps one word of control voltages per cycle to voice parameters. The pitch
// knob sets a base in semitones (23..49, or -12..84 in wide range), the V/oct
// input adds 12 semitones per volt, and the pulse frequency is 27.5 Hz times
// 2^(semitones/12), scaled by the linear fm factor 1 + 0.2*fm*index and held
// to 1..20000 Hz (out in 1/256 Hz). Density, cadence, torque and shape are
// voltage/5 plus knob, clamped; shape is then scaled by 4.9999. The two switch
// bytes come out unchanged. Voltages are in 1/2048 V, knobs are Q0.16.
// Throughput is one word per cycle while the output is not stalled. The eight
// register stages are set by the pitch path: semitone sum, octave split and
// fraction products, exponential polynomial with the gain table lookup, gain
// multiply, octave shift, fm product in two partial products, sum and limit,
// then the divide by five in the output register.
// Each stage holds when the stage after it is full and stalled, so bubbles
// close up and input is taken while a finished word waits on the output.
// Knob registers are written over the cfg port, which is always ready; writes
// to index seven are dropped.
module cv_to_voice_parameter_mapper (
	input  wire                          clk,
	input  wire                          arst_n,
	// input words
	input  wire                          s_axis_tvalid,
	output logic                         s_axis_tready,
	// pitch_volts, fm_volts, fm_index_volts, density_volts, cadence_volts,
	// torque_volts, shape_volts, lock_switch, couple_switch
	input  wire [cvmap_pkg::IN_W-1:0]    s_axis_tdata,
	// output words
	output logic                         m_axis_tvalid,
	input  wire                          m_axis_tready,
	// pulse_hz, density_amount, modulation_ratio, modulation_depth,
	// waveform_position, lock_out, couple_out, zero pad
	output logic [cvmap_pkg::OUT_W-1:0]  m_axis_tdata,
	// knob register writes
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire [cvmap_pkg::CIDX_W-1:0]  cfg_index,
	input  wire [cvmap_pkg::CDAT_W-1:0]  cfg_data
);

	// knob registers
	logic [15:0] pitch_knob_q;
	logic        pitch_wide_q;
	logic        fm_patched_q;
	logic [15:0] density_knob_q;
	logic [15:0] cadence_knob_q;
	logic [15:0] torque_knob_q;
	logic [15:0] shape_knob_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_knob_q   <= 16'd32768;
			pitch_wide_q   <= 1'b0;
			fm_patched_q   <= 1'b0;
			density_knob_q <= 16'd32768;
			cadence_knob_q <= 16'd0;
			torque_knob_q  <= 16'd0;
			shape_knob_q   <= 16'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				cvmap_pkg::REG_PITCH_KNOB:   pitch_knob_q   <= cfg_data;
				cvmap_pkg::REG_PITCH_WIDE:   pitch_wide_q   <= cfg_data[0];
				cvmap_pkg::REG_FM_PATCHED:   fm_patched_q   <= cfg_data[0];
				cvmap_pkg::REG_DENSITY_KNOB: density_knob_q <= cfg_data;
				cvmap_pkg::REG_CADENCE_KNOB: cadence_knob_q <= cfg_data;
				cvmap_pkg::REG_TORQUE_KNOB:  torque_knob_q  <= cfg_data;
				cvmap_pkg::REG_SHAPE_KNOB:   shape_knob_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// floor(v/5) for a signed voltage term, by offset and reciprocal
	function automatic logic [19:0] div5_floor(input logic signed [21:0] v);
		logic [21:0] w;
		logic [41:0] prod;
		w    = v + cvmap_pkg::LIN_OFFSET;
		prod = 42'(w) * 42'(cvmap_pkg::RECIP5_22);
		return prod[41:22];
	endfunction

	// undo the offset and add the knob
	function automatic logic signed [20:0] lin_add(input logic [19:0] q,
			input logic signed [20:0] k);
		return signed'(21'(q)) - 21'sd524288 + k;
	endfunction

	function automatic logic [15:0] clamp_unit(input logic signed [20:0] v);
		logic [15:0] c;
		if (v < 21'sd0)
			c = 16'd0;
		else if (v > 21'sd65535)
			c = 16'hFFFF;
		else
			c = v[15:0];
		return c;
	endfunction

	// stage enables, filled from the output back
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic en1, en2, en3, en4, en5, en6, en7, en8;

	always_comb begin
		en8 = m_axis_tready || !v_s8;
		en7 = en8 || !v_s7;
		en6 = en7 || !v_s6;
		en5 = en6 || !v_s5;
		en4 = en5 || !v_s4;
		en3 = en4 || !v_s3;
		en2 = en3 || !v_s2;
		en1 = en2 || !v_s1;
	end

	assign s_axis_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_axis_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
			if (en8) v_s8 <= v_s7;
		end
	end

	// input fields
	logic signed [15:0] pv_in, fv_in, iv_in, dv_in, cv_in, tv_in, sv_in;
	logic [7:0]         lock_in, couple_in;

	assign pv_in     = s_axis_tdata[15:0];
	assign fv_in     = s_axis_tdata[31:16];
	assign iv_in     = s_axis_tdata[47:32];
	assign dv_in     = s_axis_tdata[63:48];
	assign cv_in     = s_axis_tdata[79:64];
	assign tv_in     = s_axis_tdata[95:80];
	assign sv_in     = s_axis_tdata[111:96];
	assign lock_in   = s_axis_tdata[119:112];
	assign couple_in = s_axis_tdata[127:120];

	// stage 1: biased semitone sum, fm product, voltage/5 quotients
	logic [6:0]         span_c;
	logic [25:0]        off_c;
	logic [22:0]        knob_term;
	logic signed [27:0] pv_term;
	logic [27:0]        u_sum;
	logic signed [15:0] idx_c;
	logic signed [31:0] g_c;

	always_comb begin
		span_c    = pitch_wide_q ? cvmap_pkg::SPAN_WIDE : cvmap_pkg::SPAN_NARROW;
		off_c     = pitch_wide_q ? cvmap_pkg::OFF_WIDE : cvmap_pkg::OFF_NARROW;
		knob_term = 23'(span_c) * 23'(pitch_knob_q);
		pv_term   = 28'(pv_in) * 28'sd384;
		// always lands in 0..2^26 thanks to the bias
		u_sum     = 28'(pv_term) + 28'(knob_term) + 28'(off_c);
		idx_c     = fm_patched_q ? iv_in : cvmap_pkg::FM_INDEX_ONE;
		g_c       = 32'(fv_in) * 32'(idx_c);
	end

	logic [25:0]        u_s1;
	logic signed [31:0] g_s1;
	logic [19:0]        dq_s1, cq_s1, tq_s1, sq_s1;
	logic [7:0]         lock_s1, couple_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			u_s1      <= u_sum[25:0];
			g_s1      <= g_c;
			dq_s1     <= div5_floor(22'(dv_in) <<< 4);
			cq_s1     <= div5_floor(22'(cv_in) <<< 5);
			tq_s1     <= div5_floor(22'(tv_in) <<< 5);
			sq_s1     <= div5_floor(22'(sv_in) <<< 5);
			lock_s1   <= lock_in;
			couple_s1 <= couple_in;
		end
	end

	// stage 2: octave and semitone split, fraction products, fm factor, clamps
	logic [9:0]         n_c;
	logic [15:0]        f_c;
	logic [18:0]        oct_prod;
	logic [5:0]         oct_c;
	logic [9:0]         r_full;
	logic [35:0]        fa_prod;
	logic signed [31:0] nn_c;
	logic signed [20:0] dens_v, cad_v, tor_v, shp_v;
	logic signed [15:0] dens_c;
	logic [16:0]        shp_c;

	always_comb begin
		n_c      = u_s1[25:16];
		f_c      = u_s1[15:0];
		// n/12 by reciprocal, exact over the reachable range
		oct_prod = 19'(n_c) * 19'd683;
		oct_c    = oct_prod[18:13];
		r_full   = n_c - 10'(oct_c) * 10'd12;
		fa_prod  = 36'(f_c) * 36'(cvmap_pkg::EXP_C1);
		nn_c     = cvmap_pkg::FM_UNITY + g_s1;

		dens_v = lin_add(dq_s1, signed'(21'(density_knob_q)) - 21'sd32768);
		cad_v  = lin_add(cq_s1, signed'(21'(cadence_knob_q)));
		tor_v  = lin_add(tq_s1, signed'(21'(torque_knob_q)));
		shp_v  = lin_add(sq_s1, signed'(21'(shape_knob_q)));

		if (dens_v < -21'sd32768)
			dens_c = -16'sd32768;
		else if (dens_v > 21'sd32767)
			dens_c = 16'sd32767;
		else
			dens_c = dens_v[15:0];

		if (shp_v < 21'sd0)
			shp_c = 17'd0;
		else if (shp_v > 21'sd65536)
			shp_c = 17'd65536;
		else
			shp_c = shp_v[16:0];
	end

	logic [5:0]           oct_s2;
	logic [3:0]           r_s2;
	logic [31:0]          ff_s2;
	logic [19:0]          fa_s2;
	logic [30:0]          nu_s2;
	logic                 nz_s2;
	logic [16:0]          shc_s2;
	cvmap_pkg::lin_t      lin_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			oct_s2         <= oct_c;
			r_s2           <= r_full[3:0];
			ff_s2          <= 32'(f_c) * 32'(f_c);
			fa_s2          <= fa_prod[35:16];
			nu_s2          <= nn_c[30:0];
			// fm factor at or below zero pins the output to 1 Hz
			nz_s2          <= nn_c[31] || (nn_c == 32'sd0);
			shc_s2         <= shp_c;
			lin_s2.density <= dens_c;
			lin_s2.ratio   <= clamp_unit(cad_v);
			lin_s2.depth   <= clamp_unit(tor_v);
			lin_s2.wave    <= 19'd0;
			lin_s2.lock    <= lock_s1;
			lin_s2.couple  <= couple_s1;
		end
	end

	// stage 3: fractional exponent multiplier, semitone gain, shape scale
	logic [30:0] fb_prod;
	logic [24:0] m_c;

	always_comb begin
		fb_prod = 31'(ff_s2[31:16]) * 31'(cvmap_pkg::EXP_C2);
		m_c     = 25'd16777216 + 25'(fa_s2) + 25'(fb_prod[30:16]);
	end

	logic [24:0]     m_s3;
	logic [29:0]     k_s3;
	logic [5:0]      oct_s3;
	logic [30:0]     nu_s3;
	logic            nz_s3;
	logic [31:0]     y_s3;
	cvmap_pkg::lin_t lin_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			m_s3   <= m_c;
			k_s3   <= cvmap_pkg::exp_gain(r_s2);
			oct_s3 <= oct_s2;
			nu_s3  <= nu_s2;
			nz_s3  <= nz_s2;
			y_s3   <= 32'(shc_s2) * 32'(cvmap_pkg::SHAPE_GAIN);
			lin_s3 <= lin_s2;
		end
	end

	// stage 4: gain times multiplier, shape divide by 10000
	logic [63:0]     z_prod;
	cvmap_pkg::lin_t lin_c4;

	always_comb begin
		z_prod      = 64'(y_s3) * 64'(cvmap_pkg::RECIP10K_45);
		lin_c4      = lin_s3;
		lin_c4.wave = z_prod[63:45];
	end

	logic [54:0]     p_s4;
	logic [5:0]      oct_s4;
	logic [30:0]     nu_s4;
	logic            nz_s4;
	cvmap_pkg::lin_t lin_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			p_s4   <= 55'(k_s3) * 55'(m_s3);
			oct_s4 <= oct_s3;
			nu_s4  <= nu_s3;
			nz_s4  <= nz_s3;
			lin_s4 <= lin_c4;
		end
	end

	// stage 5: octave shift
	logic [5:0]  sh_c;
	logic [54:0] base_c;

	always_comb begin
		sh_c   = 6'd52 - oct_s4;
		base_c = p_s4 >> sh_c;
	end

	logic [45:0]     base_s5;
	logic [30:0]     nu_s5;
	logic            nz_s5;
	cvmap_pkg::lin_t lin_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			base_s5 <= base_c[45:0];
			nu_s5   <= nu_s4;
			nz_s5   <= nz_s4;
			lin_s5  <= lin_s4;
		end
	end

	// stage 6: fm product as two partial products
	logic [53:0]     ph_s6, pl_s6;
	logic            nz_s6;
	cvmap_pkg::lin_t lin_s6;

	always_ff @(posedge clk) begin
		if (en6) begin
			ph_s6  <= 54'(base_s5[45:23]) * 54'(nu_s5);
			pl_s6  <= 54'(base_s5[22:0]) * 54'(nu_s5);
			nz_s6  <= nz_s5;
			lin_s6 <= lin_s5;
		end
	end

	// stage 7: join partial products, scale down, range flags
	logic [76:0] sum_c;
	logic [46:0] xf_c;

	always_comb begin
		sum_c = (77'(ph_s6) << 23) + 77'(pl_s6);
		xf_c  = sum_c[76:30];
	end

	logic [24:0]     x_s7;
	logic            hi_s7, lo_s7;
	cvmap_pkg::lin_t lin_s7;

	always_ff @(posedge clk) begin
		if (en7) begin
			x_s7   <= xf_c[24:0];
			hi_s7  <= xf_c >= cvmap_pkg::X_OVER;
			lo_s7  <= nz_s6 || (xf_c < cvmap_pkg::X_MIN);
			lin_s7 <= lin_s6;
		end
	end

	// stage 8: divide by five, saturate, output register
	logic [49:0] q_prod;
	logic [22:0] pulse_c;

	always_comb begin
		q_prod = 50'(x_s7) * 50'(cvmap_pkg::RECIP5_27);
		if (lo_s7)
			pulse_c = cvmap_pkg::FREQ_MIN;
		else if (hi_s7)
			pulse_c = cvmap_pkg::FREQ_MAX;
		else
			pulse_c = q_prod[49:27];
	end

	logic [22:0]     pulse_s8;
	cvmap_pkg::lin_t lin_s8;

	always_ff @(posedge clk) begin
		if (en8) begin
			pulse_s8 <= pulse_c;
			lin_s8   <= lin_s7;
		end
	end

	assign m_axis_tvalid = v_s8;
	assign m_axis_tdata  = {6'd0, lin_s8.couple, lin_s8.lock, lin_s8.wave, lin_s8.depth,
		lin_s8.ratio, lin_s8.density, pulse_s8};

endmodule

`default_nettype wire
